// ===== rtl/lre_pkg.sv =====
package lre_pkg;

  localparam int COORD_BITS = 16;
  // magnitude of dir * (edge - line origin) fits in 2*COORD_BITS bits
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int CNT_W      = $clog2(PROD_W + 1);
  // crossing coordinate before truncation to the field width
  localparam int V_W        = COORD_BITS + 2;
  localparam int NEDGE      = 4;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_TOP    = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_t;

  typedef enum logic [1:0] {
    REG_LINE_X = 2'd0,
    REG_LINE_Y = 2'd1,
    REG_DIR_X  = 2'd2,
    REG_DIR_Y  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_DIV   = 2'd1,
    B_CHECK = 2'd2,
    B_EMIT  = 2'd3
  } back_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rect_left;
    logic signed [COORD_BITS-1:0] rect_top;
    logic signed [COORD_BITS-1:0] rect_right;
    logic signed [COORD_BITS-1:0] rect_bottom;
  } rect_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] hit_x;
    logic signed [COORD_BITS-1:0] hit_y;
    logic [1:0]                   edge_res;
    logic                         hit_valid;
    logic                         last;
  } res_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] line_x;
    logic signed [COORD_BITS-1:0] line_y;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
  } cfg_t;

  // classified work for one rectangle
  typedef struct packed {
    rect_t                            rect;
    logic                             en_x;
    logic                             en_y;
    logic [COORD_BITS-1:0]            den_x_mag;
    logic [COORD_BITS-1:0]            den_y_mag;
    logic [NEDGE-1:0][PROD_W-1:0]     mag;
    logic [NEDGE-1:0]                 neg;
    logic [NEDGE-1:0][COORD_BITS-1:0] base;
  } work_t;

endpackage

// ===== rtl/line_rect_edge_intersections_top.sv =====
// Line against rectangle edge crossings. The line (point and direction) is
// set through the write port; each rectangle transferred in gives one to four
// crossing results in the order left, top, right, bottom, or a single result
// with hit_valid clear, and last marks the final result of a rectangle.
// The front stage forms the four products combinationally and registers them;
// two rectangles can be queued ahead of the back end, so input keeps moving
// while results wait. The back end runs four restoring dividers in parallel,
// one quotient bit per cycle: a rectangle occupies it through the divide, check
// and emit states, and the next one is taken only after its last result is out.
module line_rect_edge_intersections_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lre_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lre_pkg::COORD_BITS-1:0]    cfg_data,
  input  logic                              rect_valid,
  output logic                              rect_stall,
  input  lre_pkg::rect_t                    rect,
  output logic                              res_valid,
  input  logic                              res_stall,
  output lre_pkg::res_t                     res
);

  lre_pkg::cfg_t  cfg;
  lre_pkg::work_t wq_in, wq_out;
  logic           push, pop, full, empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (lre_pkg::reg_idx_t'(cfg_idx))
        lre_pkg::REG_LINE_X: cfg.line_x <= cfg_data;
        lre_pkg::REG_LINE_Y: cfg.line_y <= cfg_data;
        lre_pkg::REG_DIR_X:  cfg.dir_x  <= cfg_data;
        lre_pkg::REG_DIR_Y:  cfg.dir_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  lre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rect_valid (rect_valid),
    .rect_stall (rect_stall),
    .rect       (rect),
    .push       (push),
    .work       (wq_in),
    .full       (full)
  );

  lre_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wq_in),
    .pop   (pop),
    .rdata (wq_out),
    .full  (full),
    .empty (empty)
  );

  lre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop       (pop),
    .work      (wq_out),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("work queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("work queue read while empty");

  a_nohit_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.hit_valid |-> res.last && (res.edge_res == 2'd0))
    else $error("no-hit result not final or not cleared");

endmodule

// ===== rtl/lre_div.sv =====
module lre_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lre_pkg::PROD_W-1:0]          dividend,
  input  logic [lre_pkg::COORD_BITS-1:0]      divisor,
  output logic                                busy,
  output logic [lre_pkg::PROD_W-1:0]          quotient
);

  localparam int C  = lre_pkg::COORD_BITS;
  localparam int PW = lre_pkg::PROD_W;

  logic [C-1:0]             rem;
  logic [C-1:0]             div_q;
  logic [PW-1:0]            quo;
  logic [lre_pkg::CNT_W-1:0] cnt;
  logic [C:0]               sh;
  logic [C:0]               diff;
  logic                     take;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    sh   = {rem, quo[PW-1]};
    diff = sh - {1'b0, div_q};
    take = (sh >= {1'b0, div_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= lre_pkg::CNT_W'(PW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      div_q <= divisor;
    end else if (cnt != '0) begin
      rem <= take ? diff[C-1:0] : sh[C-1:0];
      quo <= {quo[PW-2:0], take};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

// ===== rtl/lre_fifo.sv =====
module lre_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lre_pkg::work_t  wdata,
  input  logic            pop,
  output lre_pkg::work_t  rdata,
  output logic            full,
  output logic            empty
);

  lre_pkg::work_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rdata = mem[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

// ===== rtl/lre_front.sv =====
module lre_front (
  input  logic            clk,
  input  logic            rst,
  input  lre_pkg::cfg_t   cfg,
  input  logic            rect_valid,
  output logic            rect_stall,
  input  lre_pkg::rect_t  rect,
  output logic            push,
  output lre_pkg::work_t  work,
  input  logic            full
);

  localparam int C = lre_pkg::COORD_BITS;

  logic                    stage_valid;
  lre_pkg::work_t          stage;
  lre_pkg::work_t          stage_next;
  logic                    load;
  logic signed [C-1:0]     num  [lre_pkg::NEDGE];
  logic signed [C-1:0]     den  [lre_pkg::NEDGE];
  logic signed [C-1:0]     edg  [lre_pkg::NEDGE];
  logic signed [C-1:0]     org  [lre_pkg::NEDGE];
  logic signed [C-1:0]     bas  [lre_pkg::NEDGE];
  logic signed [C:0]       dif  [lre_pkg::NEDGE];
  logic signed [2*C:0]     prod [lre_pkg::NEDGE];
  logic signed [2*C:0]     pabs [lre_pkg::NEDGE];

  // per-edge operands: sides divide by dir_x, top/bottom by dir_y
  always_comb begin
    num[0] = cfg.dir_y; den[0] = cfg.dir_x; edg[0] = rect.rect_left;
    org[0] = cfg.line_x; bas[0] = cfg.line_y;
    num[1] = cfg.dir_x; den[1] = cfg.dir_y; edg[1] = rect.rect_top;
    org[1] = cfg.line_y; bas[1] = cfg.line_x;
    num[2] = cfg.dir_y; den[2] = cfg.dir_x; edg[2] = rect.rect_right;
    org[2] = cfg.line_x; bas[2] = cfg.line_y;
    num[3] = cfg.dir_x; den[3] = cfg.dir_y; edg[3] = rect.rect_bottom;
    org[3] = cfg.line_y; bas[3] = cfg.line_x;
  end

  // products and sign of the quotient
  always_comb begin
    stage_next           = '0;
    stage_next.rect      = rect;
    stage_next.en_x      = (cfg.dir_x != '0);
    stage_next.en_y      = (cfg.dir_y != '0);
    stage_next.den_x_mag = cfg.dir_x[C-1] ? C'(-cfg.dir_x) : cfg.dir_x;
    stage_next.den_y_mag = cfg.dir_y[C-1] ? C'(-cfg.dir_y) : cfg.dir_y;
    for (int i = 0; i < lre_pkg::NEDGE; i++) begin
      dif[i]  = {edg[i][C-1], edg[i]} - {org[i][C-1], org[i]};
      prod[i] = {{(C+1){num[i][C-1]}}, num[i]} * {{C{dif[i][C]}}, dif[i]};
      pabs[i] = prod[i][2*C] ? -prod[i] : prod[i];
      stage_next.mag[i]  = pabs[i][lre_pkg::PROD_W-1:0];
      stage_next.neg[i]  = prod[i][2*C] ^ den[i][C-1];
      stage_next.base[i] = bas[i];
    end
  end

  assign push       = stage_valid && !full;
  assign load       = !stage_valid || push;
  assign rect_stall = !load;
  assign work       = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= rect_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && rect_valid) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== rtl/lre_back.sv =====
module lre_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  output logic            pop,
  input  lre_pkg::work_t  work,
  output logic            res_valid,
  input  logic            res_stall,
  output lre_pkg::res_t   res
);

  localparam int C  = lre_pkg::COORD_BITS;
  localparam int VW = lre_pkg::V_W;
  localparam int PW = lre_pkg::PROD_W;

  lre_pkg::back_state_t state, state_next;
  lre_pkg::work_t       cur;
  logic [lre_pkg::NEDGE-1:0]        busy;
  logic [lre_pkg::NEDGE-1:0][PW-1:0] quo;
  logic [lre_pkg::NEDGE-1:0][C-1:0]  dvs;
  logic [lre_pkg::NEDGE-1:0]        mask;
  logic [lre_pkg::NEDGE-1:0]        mask_next;
  logic [lre_pkg::NEDGE-1:0][C-1:0] hx, hy;
  logic [lre_pkg::NEDGE-1:0][C-1:0] hx_next, hy_next;
  logic signed [VW-1:0] v   [lre_pkg::NEDGE];
  logic signed [VW-1:0] qs  [lre_pkg::NEDGE];
  logic [C:0]           qc  [lre_pkg::NEDGE];
  logic signed [VW-1:0] el, et, er, eb;
  logic                 start;
  logic                 out_free;
  logic                 emit;
  logic [lre_pkg::NEDGE-1:0] pick;
  logic [lre_pkg::NEDGE-1:0] rest;
  lre_pkg::res_t        item;

  // disabled lanes divide by one; their results are ignored
  always_comb begin
    dvs[0] = work.en_x ? work.den_x_mag : C'(1);
    dvs[2] = dvs[0];
    dvs[1] = work.en_y ? work.den_y_mag : C'(1);
    dvs[3] = dvs[1];
  end

  for (genvar g = 0; g < lre_pkg::NEDGE; g++) begin : g_div
    lre_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (start),
      .dividend (work.mag[g]),
      .divisor  (dvs[g]),
      .busy     (busy[g]),
      .quotient (quo[g])
    );
  end

  // clamp, sign, add base, and the half-open edge tests
  always_comb begin
    el = VW'(cur.rect.rect_left);
    et = VW'(cur.rect.rect_top);
    er = VW'(cur.rect.rect_right);
    eb = VW'(cur.rect.rect_bottom);
    for (int i = 0; i < lre_pkg::NEDGE; i++) begin
      qc[i] = (quo[i] > PW'(1 << C)) ? (C+1)'(1 << C) : quo[i][C:0];
      qs[i] = cur.neg[i] ? -VW'(qc[i]) : VW'(qc[i]);
      v[i]  = VW'($signed(cur.base[i])) + qs[i];
    end
    mask_next[0] = cur.en_x && (v[0] >= et) && (v[0] < eb);
    mask_next[1] = cur.en_y && (v[1] <= er) && (v[1] > el);
    mask_next[2] = cur.en_x && (v[2] > et) && (v[2] <= eb);
    mask_next[3] = cur.en_y && (v[3] < er) && (v[3] >= el);
    hx_next[0] = cur.rect.rect_left;  hy_next[0] = v[0][C-1:0];
    hx_next[1] = v[1][C-1:0];         hy_next[1] = cur.rect.rect_top;
    hx_next[2] = cur.rect.rect_right; hy_next[2] = v[2][C-1:0];
    hx_next[3] = v[3][C-1:0];         hy_next[3] = cur.rect.rect_bottom;
  end

  // lowest pending edge goes out first
  always_comb begin
    pick = mask & (~mask + 1'b1);
    rest = mask & ~pick;
    item = '0;
    item.last = (rest == '0);
    for (int i = 0; i < lre_pkg::NEDGE; i++) begin
      if (pick[i]) begin
        item.hit_x     = hx[i];
        item.hit_y     = hy[i];
        item.edge_res  = 2'(i);
        item.hit_valid = 1'b1;
      end
    end
  end

  assign out_free = !res_valid || !res_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lre_pkg::B_IDLE:  if (!empty) state_next = lre_pkg::B_DIV;
      lre_pkg::B_DIV:   if (busy == '0) state_next = lre_pkg::B_CHECK;
      lre_pkg::B_CHECK: state_next = lre_pkg::B_EMIT;
      lre_pkg::B_EMIT:  if (out_free && item.last) state_next = lre_pkg::B_IDLE;
      default: state_next = lre_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop   = 1'b0;
    start = 1'b0;
    emit  = 1'b0;
    unique case (state)
      lre_pkg::B_IDLE: begin
        pop   = !empty;
        start = !empty;
      end
      lre_pkg::B_EMIT: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lre_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= work;
    if (state == lre_pkg::B_CHECK) begin
      mask <= mask_next;
      hx   <= hx_next;
      hy   <= hy_next;
    end else if (emit) begin
      mask <= rest;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= item;
  end

endmodule

// ===== verif/line_rect_edge_intersections_top_tb.sv =====
`timescale 1ns / 100ps

module line_rect_edge_intersections_top_tb;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lre_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lre_pkg::COORD_BITS-1:0] cfg_data;
  logic rect_valid;
  logic rect_stall;
  lre_pkg::rect_t rect;
  logic res_valid;
  logic res_stall;
  lre_pkg::res_t res;

  line_rect_edge_intersections_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .rect_valid(rect_valid), .rect_stall(rect_stall), .rect(rect),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // line settings as the block holds them
  logic signed [lre_pkg::COORD_BITS-1:0] pt_x, pt_y, dx, dy;
  lre_pkg::res_t crossings_q[$];
  int err_count;
  int cycle_count;
  bit idle_on;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_rect_edge_intersections_top_tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // base + trunc(num*diff/den), quotient clamped to +-2^COORD_BITS
  function automatic longint cross_coord(longint base, longint num, longint diff,
                                         longint den);
    longint lim;
    longint q;
    lim = longint'(1) << lre_pkg::COORD_BITS;
    q = (num * diff) / den;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return base + q;
  endfunction

  function automatic lre_pkg::res_t mk_res(longint x, longint y, lre_pkg::edge_t e,
                                           logic v);
    lre_pkg::res_t r;
    r.hit_x = x[lre_pkg::COORD_BITS-1:0];
    r.hit_y = y[lre_pkg::COORD_BITS-1:0];
    r.edge_res = e;
    r.hit_valid = v;
    r.last = 1'b0;
    return r;
  endfunction

  // append one expected result
  function automatic void add_expected(lre_pkg::res_t r);
    crossings_q = {crossings_q, r};
  endfunction

  // expected crossings of one rectangle, queued in edge order
  task automatic predict_crossings(input lre_pkg::rect_t rc);
    longint l, t, r, b, v;
    int n;
    l = rc.rect_left; t = rc.rect_top; r = rc.rect_right; b = rc.rect_bottom;
    n = 0;
    if (dx != 0) begin
      v = cross_coord(pt_y, dy, l - pt_x, dx);
      if (v >= t && v < b) begin add_expected(mk_res(l, v, lre_pkg::EDGE_LEFT, 1)); n++; end
    end
    if (dy != 0) begin
      v = cross_coord(pt_x, dx, t - pt_y, dy);
      if (v <= r && v > l) begin add_expected(mk_res(v, t, lre_pkg::EDGE_TOP, 1)); n++; end
    end
    if (dx != 0) begin
      v = cross_coord(pt_y, dy, r - pt_x, dx);
      if (v > t && v <= b) begin add_expected(mk_res(r, v, lre_pkg::EDGE_RIGHT, 1)); n++; end
    end
    if (dy != 0) begin
      v = cross_coord(pt_x, dx, b - pt_y, dy);
      if (v < r && v >= l) begin
        add_expected(mk_res(v, b, lre_pkg::EDGE_BOTTOM, 1));
        n++;
      end
    end
    if (n == 0) add_expected(mk_res(0, 0, lre_pkg::EDGE_LEFT, 0));
    crossings_q[$].last = 1'b1;
  endtask

  function automatic bit idle_now();
    return idle_on && ($urandom_range(0, 99) < 14);
  endfunction

  // result checker with random stall
  always @(posedge clk) begin
    lre_pkg::res_t exp_r;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (crossings_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = crossings_q.pop_front();
          if (res.hit_x !== exp_r.hit_x)
            report_mismatch($sformatf("hit_x %0d exp %0d", res.hit_x, exp_r.hit_x));
          if (res.hit_y !== exp_r.hit_y)
            report_mismatch($sformatf("hit_y %0d exp %0d", res.hit_y, exp_r.hit_y));
          if (res.edge_res !== exp_r.edge_res)
            report_mismatch($sformatf("edge %0d exp %0d", res.edge_res, exp_r.edge_res));
          if (res.hit_valid !== exp_r.hit_valid)
            report_mismatch($sformatf("hit_valid %0b exp %0b", res.hit_valid,
                                      exp_r.hit_valid));
          if (res.last !== exp_r.last)
            report_mismatch($sformatf("last %0b exp %0b", res.last, exp_r.last));
        end
      end
      res_stall <= idle_now();
    end
  end

  // one rectangle transfer; gap chosen before raising valid
  task automatic send_rect(input lre_pkg::rect_t rc);
    while (idle_now()) begin
      rect_valid <= 1'b0;
      @(posedge clk);
    end
    rect <= rc;
    rect_valid <= 1'b1;
    predict_crossings(rc);
    @(posedge clk);
    while (rect_stall) @(posedge clk);
  endtask

  task automatic write_reg(input lre_pkg::reg_idx_t idx,
                           input logic [lre_pkg::COORD_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      lre_pkg::REG_LINE_X: pt_x = val;
      lre_pkg::REG_LINE_Y: pt_y = val;
      lre_pkg::REG_DIR_X:  dx = val;
      default:             dy = val;
    endcase
  endtask

  // wait until all results are in, then let the back end settle
  task automatic drain();
    rect_valid <= 1'b0;
    while (crossings_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_line(input logic [lre_pkg::COORD_BITS-1:0] x, y, ddx, ddy);
    drain();
    write_reg(lre_pkg::REG_LINE_X, x);
    write_reg(lre_pkg::REG_LINE_Y, y);
    write_reg(lre_pkg::REG_DIR_X, ddx);
    write_reg(lre_pkg::REG_DIR_Y, ddy);
    cfg_we <= 1'b0;
  endtask

  function automatic lre_pkg::rect_t mk_rect(int l, int t, int r, int b);
    lre_pkg::rect_t rc;
    rc.rect_left = 16'(l); rc.rect_top = 16'(t);
    rc.rect_right = 16'(r); rc.rect_bottom = 16'(b);
    return rc;
  endfunction

  function automatic lre_pkg::rect_t rand_rect();
    lre_pkg::rect_t rc;
    int cx, cy, w, h;
    if ($urandom_range(0, 9) < 2) begin
      rc = {$urandom, $urandom};
      return rc;
    end
    // rectangles centred at random points scaled toward the origin
    cx = $signed(16'($urandom_range(0, 65535))) / (1 << $urandom_range(0, 6));
    cy = $signed(16'($urandom_range(0, 65535))) / (1 << $urandom_range(0, 6));
    w = $urandom_range(0, 1 << $urandom_range(2, 14));
    h = $urandom_range(0, 1 << $urandom_range(2, 14));
    rc.rect_left = 16'(cx - w);
    rc.rect_right = 16'(cx + w);
    rc.rect_top = 16'(cy - h);
    rc.rect_bottom = 16'(cy + h);
    return rc;
  endfunction

  // diagonal, axis-parallel and degenerate lines against fixed boxes
  task automatic test_directed();
    set_line(0, 0, 16'sd16, 16'sd16);
    send_rect(mk_rect(-160, -160, 160, 160));
    send_rect(mk_rect(0, 0, 160, 160));
    send_rect(mk_rect(160, -160, -160, 160));
    send_rect(mk_rect(-32768, -32768, 32767, 32767));
    send_rect(mk_rect(500, -500, 600, -400));
    set_line(16'sd40, -16'sd80, 0, 16'sd3);
    send_rect(mk_rect(-160, -160, 160, 160));
    send_rect(mk_rect(40, -160, 160, 160));
    send_rect(mk_rect(-160, -160, 40, 160));
    set_line(-16'sd100, 16'sd50, -16'sd7, 0);
    send_rect(mk_rect(-160, -160, 160, 160));
    send_rect(mk_rect(-160, 50, 160, 160));
    send_rect(mk_rect(-160, -160, 160, 50));
    set_line(16'sd100, 16'sd100, 0, 0);
    send_rect(mk_rect(-160, -160, 160, 160));
    set_line(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_rect(mk_rect(-32768, -32768, 32767, 32767));
    send_rect(mk_rect(0, 0, 1, 1));
    set_line(16'h8000, 16'h7fff, 16'sd1, 16'h7fff);
    send_rect(mk_rect(-32768, -32768, 32767, 32767));
    send_rect(mk_rect(-32767, 100, -32760, 32767));
    send_rect(mk_rect(-100, -100, 100, 100));
  endtask

  // random lines, each followed by a burst of rectangles
  task automatic test_random();
    logic [lre_pkg::COORD_BITS-1:0] ddx, ddy;
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph != 5);
      ddx = $urandom; ddy = $urandom;
      if (ph % 4 == 1) ddx = 0;
      if (ph % 4 == 2) ddy = 0;
      if (ph % 3 == 0) begin
        ddx = $signed(ddx) >>> $urandom_range(0, 12);
        ddy = $signed(ddy) >>> $urandom_range(0, 12);
      end
      set_line($signed(16'($urandom)) >>> $urandom_range(0, 6),
               $signed(16'($urandom)) >>> $urandom_range(0, 6), ddx, ddy);
      for (int i = 0; i < 40; i++) send_rect(rand_rect());
    end
    idle_on = 1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = lre_pkg::REG_LINE_X;
    cfg_data = '0;
    rect_valid = 1'b0;
    rect = '0;
    pt_x = 0; pt_y = 0; dx = 0; dy = 0;
    err_count = 0;
    cycle_count = 0;
    idle_on = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (err_count == 0) begin
      $display("line_rect_edge_intersections_top_tb passed");
    end else begin
      $display("line_rect_edge_intersections_top_tb failed");
    end
    $finish;
  end

endmodule
